// ===== sv/ukf_pkg.sv =====
package ukf_pkg;

   localparam int VERTICES = 1024;
   localparam int VID_W    = 11;
   localparam int ADDR_W   = $clog2(VERTICES);
   localparam int SIZE_W   = $clog2(VERTICES) + 1;
   localparam int WEIGHT_W = 20;
   localparam int CNT_W    = 10;

   // One word of the union-find store: parent held as an address (vertex id minus one).
   typedef struct packed {
      logic [ADDR_W-1:0] parent;
      logic [SIZE_W-1:0] size;
   } mem_word_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      mem_word_type      wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic                accepted;
      logic [CNT_W-1:0]    tree_edges;
      logic [WEIGHT_W-1:0] max_weight;
      logic                complete;
      logic                bad_vertex;
   } result_type;

endpackage

// ===== sv/ukf_mem.sv =====
module ukf_mem (
   input  logic                 clock,
   input  ukf_pkg::mem_req_type mem_req,
   output ukf_pkg::mem_word_type rd_data
);
   import ukf_pkg::*;

   mem_word_type mem [VERTICES];
   mem_word_type rd_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_ff;

endmodule

// ===== sv/ukf_ctrl.sv =====
module ukf_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ukf_pkg::VID_W-1:0]     vertex_count,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  logic [ukf_pkg::VID_W-1:0]     end_a,
   input  logic [ukf_pkg::VID_W-1:0]     end_b,
   input  logic [ukf_pkg::WEIGHT_W-1:0]  weight,
   input  logic                          new_graph,
   input  logic                          out_free,
   output logic                          res_valid,
   output ukf_pkg::result_type           res,
   output ukf_pkg::mem_req_type          mem_req,
   input  ukf_pkg::mem_word_type         rd_data
);
   import ukf_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_FIND, ST_COMP, ST_UNION, ST_UN2, ST_DONE
   } state_type;

   state_type           state_ff;
   logic                boot_ff;
   logic [ADDR_W-1:0]   clr_ff;
   logic [VID_W-1:0]    a_ff, b_ff;
   logic [WEIGHT_W-1:0] w_ff;
   logic [ADDR_W-1:0]   cur_ff, start_ff, root_ff;
   logic                which_ff;
   logic [ADDR_W-1:0]   root_a_ff, root_b_ff;
   logic [SIZE_W-1:0]   size_a_ff, size_b_ff;
   logic [ADDR_W-1:0]   big_ff;
   logic [SIZE_W-1:0]   sum_ff;
   logic [CNT_W-1:0]    tree_ff;
   logic [WEIGHT_W-1:0] heavy_ff;
   logic                acc_ff, bad_ff;
   logic                res_valid_ff;

   logic [VID_W-1:0]    n_eff;
   logic                complete;
   logic                bad_now;
   logic [VID_W-1:0]    a_m1, b_m1;
   logic [ADDR_W-1:0]   a_addr, b_addr;

   assign n_eff    = (vertex_count > VID_W'(VERTICES)) ? VID_W'(VERTICES) : vertex_count;
   assign complete = (n_eff != '0) && ({1'b0, tree_ff} >= (n_eff - VID_W'(1)));
   assign bad_now  = (a_ff == '0) || (a_ff > n_eff) || (b_ff == '0) || (b_ff > n_eff);
   assign a_m1     = a_ff - VID_W'(1);
   assign b_m1     = b_ff - VID_W'(1);
   assign a_addr   = a_m1[ADDR_W-1:0];
   assign b_addr   = b_m1[ADDR_W-1:0];

   assign item_ready = (state_ff == ST_IDLE);

   always_comb begin
      mem_req = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.we           = 1'b1;
            mem_req.waddr        = clr_ff;
            mem_req.wdata.parent = clr_ff;
            mem_req.wdata.size   = SIZE_W'(1);
         end
         ST_CHECK: mem_req.raddr = a_addr;
         ST_FIND: begin
            if (rd_data.parent != cur_ff) begin
               mem_req.raddr = rd_data.parent;
            end else if (start_ff != cur_ff) begin
               mem_req.raddr = start_ff;
            end else begin
               mem_req.raddr = b_addr;
            end
         end
         ST_COMP: begin
            mem_req.we           = 1'b1;
            mem_req.waddr        = cur_ff;
            mem_req.wdata.parent = root_ff;
            mem_req.wdata.size   = rd_data.size;
            mem_req.raddr        = (rd_data.parent == root_ff) ? b_addr : rd_data.parent;
         end
         ST_UNION: begin
            // Hang the smaller root under the larger one; its size entry stays as is.
            mem_req.we = (root_a_ff != root_b_ff);
            if (size_a_ff > size_b_ff) begin
               mem_req.waddr        = root_b_ff;
               mem_req.wdata.parent = root_a_ff;
               mem_req.wdata.size   = size_b_ff;
            end else begin
               mem_req.waddr        = root_a_ff;
               mem_req.wdata.parent = root_b_ff;
               mem_req.wdata.size   = size_a_ff;
            end
         end
         ST_UN2: begin
            mem_req.we           = 1'b1;
            mem_req.waddr        = big_ff;
            mem_req.wdata.parent = big_ff;
            mem_req.wdata.size   = sum_ff;
         end
         default: mem_req = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         clr_ff       <= '0;
         tree_ff      <= '0;
         heavy_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == ADDR_W'(VERTICES - 1)) begin
                  boot_ff  <= 1'b0;
                  state_ff <= boot_ff ? ST_IDLE : ST_CHECK;
               end
            end
            ST_IDLE: begin
               if (item_valid) begin
                  a_ff   <= end_a;
                  b_ff   <= end_b;
                  w_ff   <= weight;
                  acc_ff <= 1'b0;
                  if (new_graph) begin
                     tree_ff  <= '0;
                     heavy_ff <= '0;
                     clr_ff   <= '0;
                     state_ff <= ST_CLEAR;
                  end else begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               bad_ff   <= bad_now;
               cur_ff   <= a_addr;
               start_ff <= a_addr;
               which_ff <= 1'b0;
               state_ff <= (bad_now || complete) ? ST_DONE : ST_FIND;
            end
            ST_FIND: begin
               if (rd_data.parent != cur_ff) begin
                  cur_ff <= rd_data.parent;
               end else begin
                  root_ff <= cur_ff;
                  if (which_ff) begin
                     root_b_ff <= cur_ff;
                     size_b_ff <= rd_data.size;
                  end else begin
                     root_a_ff <= cur_ff;
                     size_a_ff <= rd_data.size;
                  end
                  if (start_ff != cur_ff) begin
                     cur_ff   <= start_ff;
                     state_ff <= ST_COMP;
                  end else if (which_ff) begin
                     state_ff <= ST_UNION;
                  end else begin
                     which_ff <= 1'b1;
                     cur_ff   <= b_addr;
                     start_ff <= b_addr;
                  end
               end
            end
            ST_COMP: begin
               if (rd_data.parent != root_ff) begin
                  cur_ff <= rd_data.parent;
               end else if (which_ff) begin
                  state_ff <= ST_UNION;
               end else begin
                  which_ff <= 1'b1;
                  cur_ff   <= b_addr;
                  start_ff <= b_addr;
                  state_ff <= ST_FIND;
               end
            end
            ST_UNION: begin
               if (root_a_ff != root_b_ff) begin
                  acc_ff  <= 1'b1;
                  tree_ff <= tree_ff + CNT_W'(1);
                  if (w_ff > heavy_ff) begin
                     heavy_ff <= w_ff;
                  end
                  big_ff   <= (size_a_ff > size_b_ff) ? root_a_ff : root_b_ff;
                  sum_ff   <= size_a_ff + size_b_ff;
                  state_ff <= ST_UN2;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_UN2: state_ff <= ST_DONE;
            ST_DONE: begin
               if (out_free) begin
                  res_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign res_valid      = res_valid_ff;
   assign res.accepted   = acc_ff;
   assign res.tree_edges = tree_ff;
   assign res.max_weight = heavy_ff;
   assign res.complete   = complete;
   assign res.bad_vertex = bad_ff;

`ifndef SYNTHESIS
   a_acc_not_bad: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(res.accepted && res.bad_vertex))
      else $error("accepted edge reported with a bad vertex");

   a_tree_step: assert property (@(posedge clock) disable iff (reset)
      (tree_ff != $past(tree_ff)) |-> (tree_ff == $past(tree_ff) + CNT_W'(1) || tree_ff == '0))
      else $error("tree edge count jumped");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_req.we)
      else $error("store written while idle");

   a_pulse_once: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> !res_valid)
      else $error("result word issued twice");
`endif

endmodule

// ===== sv/kruskal_union_find_edge_filter_core.sv =====
// A bad vertex or a complete tree is answered straight after the check. Any other edge first walks
// from each endpoint to its root and then compresses that path (find walk and compression pass);
// an accepted edge then hangs the smaller root under the larger and updates the larger one's size.
// The next word is taken only after the result of the last one has been issued; words never overlap.
// A word with new_graph set first runs a sweep that clears the store.
// Reset is synchronous and active high; the same sweep runs first and vertex_count is 1024.
module kruskal_union_find_edge_filter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // end_a, end_b, weight, zero fill
   input  logic        req_tuser,   // new_graph
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // accepted, tree_edges, max_weight, complete,
                                    // bad_vertex, zero fill
);
   import ukf_pkg::*;

   logic [VID_W-1:0] vcount_ff;
   logic             rsp_valid_ff;
   result_type       rsp_ff;
   logic             out_free;
   logic             res_valid;
   result_type       res;
   mem_req_type      mem_req;
   mem_word_type     rd_data;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VID_W'(VERTICES);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   ukf_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .vertex_count (vcount_ff),
      .item_valid   (req_tvalid),
      .item_ready   (req_tready),
      .end_a        (req_tdata[10:0]),
      .end_b        (req_tdata[21:11]),
      .weight       (req_tdata[41:22]),
      .new_graph    (req_tuser),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res),
      .mem_req      (mem_req),
      .rd_data      (rd_data)
   );

   ukf_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.bad_vertex, rsp_ff.complete, rsp_ff.max_weight,
                        rsp_ff.tree_edges, rsp_ff.accepted};

endmodule
